@@ rtl/qpr_pkg.sv @@
`timescale 1ns / 1ps

package qpr_pkg;

  // coordinate and quaternion formats
  typedef logic signed [31:0] coord_t;   // Q16.16
  typedef logic signed [15:0] quat_t;    // Q1.14
  typedef logic signed [29:0] qprod_t;   // component product, Q.28
  typedef logic signed [30:0] coef_t;    // coefficient, units of 2^-27
  typedef logic signed [62:0] mprod_t;   // coefficient times coordinate
  typedef logic signed [64:0] acc_t;     // sum of three products plus rounding
  typedef logic signed [37:0] shr_t;     // accumulator after the output shift

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_QX = 2'd0,
    REG_QY = 2'd1,
    REG_QZ = 2'd2,
    REG_QW = 2'd3
  } reg_idx_t;

  localparam quat_t QONE      = 16'sd16384;
  localparam quat_t QONE_NEG  = -16'sd16384;
  localparam coef_t HALF_Q28  = 31'sd134217728;   // 2^27
  localparam acc_t  ROUND_ADD = 65'sd67108864;    // 2^26
  localparam int    SHIFT_OUT = 27;
  localparam shr_t  SAT_MAX   = 38'sd2147483647;
  localparam shr_t  SAT_MIN   = -38'sd2147483648;

  // cycles the coefficient pipeline needs after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // nine rotation coefficients and the identity flag
  typedef struct packed {
    logic  bypass;
    coef_t m00;
    coef_t m01;
    coef_t m02;
    coef_t m10;
    coef_t m11;
    coef_t m12;
    coef_t m20;
    coef_t m21;
    coef_t m22;
  } coef_set_t;

  // limit a component to [-1.0, 1.0]
  function automatic quat_t clamp_q(input quat_t v);
    quat_t r;
    if (v > QONE) r = QONE;
    else if (v < QONE_NEG) r = QONE_NEG;
    else r = v;
    return r;
  endfunction

endpackage

@@ rtl/qpr_if.sv @@
`timescale 1ns / 1ps

// point beat channel
interface qpr_pt_if;
  logic            valid;
  logic            ready;
  qpr_pkg::coord_t point_x;
  qpr_pkg::coord_t point_y;
  qpr_pkg::coord_t point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

// rotated point beat channel
interface qpr_rot_if;
  logic            valid;
  logic            ready;
  qpr_pkg::coord_t rot_x;
  qpr_pkg::coord_t rot_y;
  qpr_pkg::coord_t rot_z;
  logic            clipped;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output clipped, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                  input clipped, output ready);
endinterface

@@ rtl/qpr_coef.sv @@
`timescale 1ns / 1ps

module qpr_coef (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  qpr_pkg::reg_idx_t   cfg_idx,
  input  qpr_pkg::quat_t      cfg_data,
  output qpr_pkg::coef_set_t  coef,
  output logic                settled
);
  import qpr_pkg::*;

  quat_t qx_r, qy_r, qz_r, qw_r;
  quat_t cx, cy, cz, cw;
  qprod_t xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic bypass_p_r;
  coef_set_t coef_r;
  logic [1:0] settle_r;

  // quaternion registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= QONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_QX:  qx_r <= cfg_data;
        REG_QY:  qy_r <= cfg_data;
        REG_QZ:  qz_r <= cfg_data;
        REG_QW:  qw_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cx = clamp_q(qx_r);
  assign cy = clamp_q(qy_r);
  assign cz = clamp_q(qz_r);
  assign cw = clamp_q(qw_r);

  // pairwise component products
  always_ff @(posedge clk) begin
    xx_r <= qprod_t'(cx * cx);
    yy_r <= qprod_t'(cy * cy);
    zz_r <= qprod_t'(cz * cz);
    xy_r <= qprod_t'(cx * cy);
    xz_r <= qprod_t'(cx * cz);
    yz_r <= qprod_t'(cy * cz);
    wx_r <= qprod_t'(cw * cx);
    wy_r <= qprod_t'(cw * cy);
    wz_r <= qprod_t'(cw * cz);
    bypass_p_r <= (qw_r == QONE);
  end

  // rotation matrix coefficients
  always_ff @(posedge clk) begin
    coef_r.bypass <= bypass_p_r;
    coef_r.m00 <= HALF_Q28 - coef_t'(yy_r) - coef_t'(zz_r);
    coef_r.m01 <= coef_t'(xy_r) - coef_t'(wz_r);
    coef_r.m02 <= coef_t'(xz_r) + coef_t'(wy_r);
    coef_r.m10 <= coef_t'(xy_r) + coef_t'(wz_r);
    coef_r.m11 <= HALF_Q28 - coef_t'(xx_r) - coef_t'(zz_r);
    coef_r.m12 <= coef_t'(yz_r) - coef_t'(wx_r);
    coef_r.m20 <= coef_t'(xz_r) - coef_t'(wy_r);
    coef_r.m21 <= coef_t'(yz_r) + coef_t'(wx_r);
    coef_r.m22 <= HALF_Q28 - coef_t'(xx_r) - coef_t'(yy_r);
  end

  // hold off new points until the coefficients reflect the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_we) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  assign coef    = coef_r;
  assign settled = (settle_r == 2'd0);

endmodule

@@ rtl/qpr_datapath.sv @@
`timescale 1ns / 1ps

module qpr_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  qpr_pkg::coef_set_t coef,
  input  logic               settled,
  qpr_pt_if.sink             in_pt,
  qpr_rot_if.source          out_rot
);
  import qpr_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: input register
  coord_t px1_r, py1_r, pz1_r;
  // stage 2: products
  coord_t px2_r, py2_r, pz2_r;
  logic   byp2_r;
  mprod_t p00_r, p01_r, p02_r, p10_r, p11_r, p12_r, p20_r, p21_r, p22_r;
  // stage 3: rounded sums
  coord_t px3_r, py3_r, pz3_r;
  logic   byp3_r;
  acc_t   ax_r, ay_r, az_r;
  // stage 4: output register
  coord_t rx_r, ry_r, rz_r;
  logic   clip_r;

  shr_t sx, sy, sz;
  coord_t qx, qy, qz;
  logic cl_x, cl_y, cl_z;

  // ready chain, a stage moves when the next one has room
  assign rdy4 = !v4_r || out_rot.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pt.ready = rdy1 && settled;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pt.valid && settled;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: capture the point beat
  always_ff @(posedge clk) begin
    if (rdy1) begin
      px1_r <= in_pt.point_x;
      py1_r <= in_pt.point_y;
      pz1_r <= in_pt.point_z;
    end
  end

  // stage 2: nine coefficient by coordinate products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      px2_r  <= px1_r;
      py2_r  <= py1_r;
      pz2_r  <= pz1_r;
      byp2_r <= coef.bypass;
      p00_r  <= mprod_t'($signed(coef.m00) * $signed(px1_r));
      p01_r  <= mprod_t'($signed(coef.m01) * $signed(py1_r));
      p02_r  <= mprod_t'($signed(coef.m02) * $signed(pz1_r));
      p10_r  <= mprod_t'($signed(coef.m10) * $signed(px1_r));
      p11_r  <= mprod_t'($signed(coef.m11) * $signed(py1_r));
      p12_r  <= mprod_t'($signed(coef.m12) * $signed(pz1_r));
      p20_r  <= mprod_t'($signed(coef.m20) * $signed(px1_r));
      p21_r  <= mprod_t'($signed(coef.m21) * $signed(py1_r));
      p22_r  <= mprod_t'($signed(coef.m22) * $signed(pz1_r));
    end
  end

  // stage 3: row sums with the rounding offset
  always_ff @(posedge clk) begin
    if (rdy3) begin
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      pz3_r  <= pz2_r;
      byp3_r <= byp2_r;
      ax_r   <= acc_t'(p00_r) + acc_t'(p01_r) + acc_t'(p02_r) + ROUND_ADD;
      ay_r   <= acc_t'(p10_r) + acc_t'(p11_r) + acc_t'(p12_r) + ROUND_ADD;
      az_r   <= acc_t'(p20_r) + acc_t'(p21_r) + acc_t'(p22_r) + ROUND_ADD;
    end
  end

  // floor shift back to Q16.16
  assign sx = shr_t'(ax_r >>> SHIFT_OUT);
  assign sy = shr_t'(ay_r >>> SHIFT_OUT);
  assign sz = shr_t'(az_r >>> SHIFT_OUT);

  // saturate each coordinate
  always_comb begin
    cl_x = (sx > SAT_MAX) || (sx < SAT_MIN);
    cl_y = (sy > SAT_MAX) || (sy < SAT_MIN);
    cl_z = (sz > SAT_MAX) || (sz < SAT_MIN);
    if (sx > SAT_MAX) qx = coord_t'(SAT_MAX);
    else if (sx < SAT_MIN) qx = coord_t'(SAT_MIN);
    else qx = coord_t'(sx);
    if (sy > SAT_MAX) qy = coord_t'(SAT_MAX);
    else if (sy < SAT_MIN) qy = coord_t'(SAT_MIN);
    else qy = coord_t'(sy);
    if (sz > SAT_MAX) qz = coord_t'(SAT_MAX);
    else if (sz < SAT_MIN) qz = coord_t'(SAT_MIN);
    else qz = coord_t'(sz);
  end

  // stage 4: output register, identity passes the point through
  always_ff @(posedge clk) begin
    if (rdy4) begin
      if (byp3_r) begin
        rx_r   <= px3_r;
        ry_r   <= py3_r;
        rz_r   <= pz3_r;
        clip_r <= 1'b0;
      end else begin
        rx_r   <= qx;
        ry_r   <= qy;
        rz_r   <= qz;
        clip_r <= cl_x || cl_y || cl_z;
      end
    end
  end

  assign out_rot.valid   = v4_r;
  assign out_rot.rot_x   = rx_r;
  assign out_rot.rot_y   = ry_r;
  assign out_rot.rot_z   = rz_r;
  assign out_rot.clipped = clip_r;

endmodule

@@ rtl/quaternion_point_rotation.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake     beat contents
// in_pt     in   valid/ready   point_x, point_y, point_z (Q16.16)
// out_rot   out  valid/ready   rot_x, rot_y, rot_z (Q16.16), clipped
// cfg       in   cfg_we        cfg_idx selects quat_x/y/z/w, cfg_data (Q1.14)
//
// one point per cycle unless out_rot stalls or the coefficients settle;
// a point passes four register stages (input, nine multipliers, row sums,
// shift and saturate) and its result beat is offered from the last of them
// coefficients come from a two stage pipeline off the quaternion registers;
// in_pt.ready drops after reset and each register write until they settle
// a stall at out_rot backs up stage by stage, every stage holds its beat

module quaternion_point_rotation (
  input  logic              clk,
  input  logic              rst_n,
  qpr_pt_if.sink            in_pt,
  qpr_rot_if.source         out_rot,
  input  logic              cfg_we,
  input  qpr_pkg::reg_idx_t cfg_idx,
  input  qpr_pkg::quat_t    cfg_data
);
  import qpr_pkg::*;

  coef_set_t coef;
  logic      settled;

  qpr_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .coef     (coef),
    .settled  (settled)
  );

  qpr_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .coef    (coef),
    .settled (settled),
    .in_pt   (in_pt),
    .out_rot (out_rot)
  );

endmodule

@@ rtl/qpr_chk.sv @@
`timescale 1ns / 1ps

module qpr_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input qpr_pkg::coord_t rot_x,
  input qpr_pkg::coord_t rot_y,
  input qpr_pkg::coord_t rot_z,
  input logic            clipped,
  input logic            cfg_we
);
  import qpr_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  // a register write holds off points while coefficients settle
  a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("point accepted while coefficients settle");

  // a clipped beat carries at least one saturated coordinate
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |->
      (rot_x == 32'sh7fffffff) || (rot_x == 32'sh80000000) ||
      (rot_y == 32'sh7fffffff) || (rot_y == 32'sh80000000) ||
      (rot_z == 32'sh7fffffff) || (rot_z == 32'sh80000000))
    else $error("clipped set without a saturated coordinate");

endmodule

bind quaternion_point_rotation qpr_chk u_qpr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_pt.ready),
  .out_valid (out_rot.valid),
  .out_ready (out_rot.ready),
  .rot_x     (out_rot.rot_x),
  .rot_y     (out_rot.rot_y),
  .rot_z     (out_rot.rot_z),
  .clipped   (out_rot.clipped),
  .cfg_we    (cfg_we)
);
